@@ hw/rtl/socd_pkg.sv @@
// shared types and constants for the socd direction cleaner
package socd_pkg;

  localparam int DIR_W   = 3;
  localparam int LAYER_W = 3;

  // number of layers with their own state set
  localparam logic [LAYER_W:0] LAYERS = (LAYER_W + 1)'(8);

  localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;

  localparam logic [1:0] SIDE_NONE    = 2'd0;
  localparam logic [1:0] SIDE_PRESS   = 2'd1;
  localparam logic [1:0] SIDE_RELEASE = 2'd2;

  localparam logic MODE_NEUTRAL  = 1'b0;
  localparam logic MODE_LAST_WIN = 1'b1;

  typedef struct packed {
    logic [DIR_W-1:0]   direction;
    logic               pressed;
    logic [LAYER_W-1:0] layer;
  } event_t;

  typedef struct packed {
    logic       pass_event;
    logic [1:0] side_action;
    logic [1:0] side_direction;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [3:0] held;
    logic [1:0] winner;
  } state_upd_t;

endpackage

@@ hw/rtl/socd_resolve.sv @@
// resolve logic: one key event against the held state of its layer
module socd_resolve (
  input  logic                 mode,
  input  socd_pkg::event_t     evt,
  input  logic [3:0]           held,
  input  logic [1:0]           winner,
  output socd_pkg::result_t    res,
  output socd_pkg::state_upd_t upd
);
  import socd_pkg::*;

  logic       dir_ok;
  logic [1:0] dir2;
  logic [1:0] opp;
  logic       axis;
  logic       first;
  logic       opp_held;
  logic [3:0] dir_bit;
  logic [1:0] axis_bit;
  logic       pass;
  logic [1:0] act;

  assign dir_ok   = (evt.direction <= DIR_RIGHT) && ({1'b0, evt.layer} < LAYERS);
  assign dir2     = evt.direction[1:0];
  assign opp      = dir2 ^ 2'd1;
  assign axis     = dir2[1];
  assign first    = ~dir2[0];
  assign opp_held = held[opp];
  assign dir_bit  = 4'b0001 << dir2;
  assign axis_bit = 2'b01 << axis;

  always_comb begin
    pass       = 1'b1;
    act        = SIDE_NONE;
    upd.we     = dir_ok;
    upd.held   = evt.pressed ? (held | dir_bit) : (held & ~dir_bit);
    upd.winner = winner;
    if (dir_ok && opp_held) begin
      if (mode == MODE_NEUTRAL) begin
        if (!axis) begin
          // up dominates down
          if (first) begin
            act = evt.pressed ? SIDE_RELEASE : SIDE_PRESS;
          end else begin
            pass = 1'b0;
          end
        end else begin
          act  = evt.pressed ? SIDE_RELEASE : SIDE_PRESS;
          pass = 1'b0;
        end
      end else begin
        if (evt.pressed) begin
          act = SIDE_RELEASE;
          if (first) begin
            upd.winner = winner | axis_bit;
          end else begin
            upd.winner = winner & ~axis_bit;
          end
        end else if (winner[axis] == first) begin
          act = SIDE_PRESS;
        end else begin
          pass = 1'b0;
        end
      end
    end
    res.pass_event     = pass;
    res.side_action    = act;
    res.side_direction = (act == SIDE_NONE) ? 2'd0 : opp;
  end

endmodule

@@ hw/rtl/socd_direction_cleaner_unit.sv @@
// top level of the socd direction cleaner: input register, state, result register
// pipeline: the event is registered in the input reg, resolved combinationally and then
// registered in the result reg, which drives the outputs
// throughput: one event per cycle while out_stall does not hold the result reg; the per-layer
// read-modify-write of held directions and axis winners completes in the cycle the event leaves the input reg
// reset: rst_n synchronous active low clears the valid flags of both stages, mode and all layer state
module socd_direction_cleaner_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [socd_pkg::DIR_W-1:0]      in_direction,
  input  logic                            in_pressed,
  input  logic [socd_pkg::LAYER_W-1:0]    in_layer,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pass_event,
  output logic [1:0]                      out_side_action,
  output logic [1:0]                      out_side_direction,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_resolve_mode
);
  import socd_pkg::*;

  localparam int NUM_LAYERS = int'(LAYERS);

  logic       mode_r;
  logic       s1_valid_r;
  event_t     s1_evt_r;
  logic       s2_valid_r;
  result_t    s2_res_r;
  logic [3:0] held_r   [NUM_LAYERS];
  logic [1:0] winner_r [NUM_LAYERS];

  logic       s2_free;
  logic       s1_move;
  logic       in_xfer;
  result_t    res;
  state_upd_t upd;

  assign cfg_ready = 1'b1;
  assign s2_free   = !s2_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && s2_free;
  assign in_stall  = s1_valid_r && !s2_free;
  assign in_xfer   = in_valid && !in_stall;

  socd_resolve u_resolve (
    .mode   (mode_r),
    .evt    (s1_evt_r),
    .held   (held_r[s1_evt_r.layer]),
    .winner (winner_r[s1_evt_r.layer]),
    .res    (res),
    .upd    (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NEUTRAL;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
        held_r[i]   <= 4'd0;
        winner_r[i] <= 2'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_resolve_mode;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      // state changes only when the event actually leaves the input reg
      if (s1_move && upd.we) begin
        held_r[s1_evt_r.layer]   <= upd.held;
        winner_r[s1_evt_r.layer] <= upd.winner;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_evt_r.direction <= in_direction;
      s1_evt_r.pressed   <= in_pressed;
      s1_evt_r.layer     <= in_layer;
    end
    if (s1_move) begin
      s2_res_r <= res;
    end
  end

  assign out_valid          = s2_valid_r;
  assign out_pass_event     = s2_res_r.pass_event;
  assign out_side_action    = s2_res_r.side_action;
  assign out_side_direction = s2_res_r.side_direction;

`ifndef NO_ASSERTIONS
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input stage");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid)
    else $error("processed event did not reach result register");

  a_side_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_side_action == SIDE_NONE) |-> out_side_direction == 2'd0)
    else $error("side direction set without side action");

  a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_side_action == SIDE_NONE || out_side_action == SIDE_PRESS ||
                   out_side_action == SIDE_RELEASE))
    else $error("illegal side action code");
`endif

endmodule

@@ tb/sv/socd_checker.sv @@
// checker for the socd direction cleaner: predicts each result and compares it
module socd_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [socd_pkg::DIR_W-1:0]   in_direction,
  input  logic                         in_pressed,
  input  logic [socd_pkg::LAYER_W-1:0] in_layer,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_pass_event,
  input  logic [1:0]                   out_side_action,
  input  logic [1:0]                   out_side_direction,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_resolve_mode,
  input  logic                         end_check,
  output int                           pending,
  output int                           fail_count
);
  import socd_pkg::*;

  localparam int NUM_LAYERS = int'(LAYERS);

  logic [3:0] held_keys   [NUM_LAYERS];
  logic [1:0] last_winner [NUM_LAYERS];
  logic       mode_q;
  logic       end_seen;
  result_t    expected_results [$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    fail_count++;
  endtask

  // works out the result of one key event and updates the layer state
  function automatic result_t resolve_event(input event_t ev);
    result_t    res;
    logic [1:0] opp;
    logic [1:0] axis_bit;
    logic [3:0] held;
    logic       axis;
    logic       first;
    logic       opp_down;
    logic       won;
    res.pass_event     = 1'b1;
    res.side_action    = SIDE_NONE;
    res.side_direction = 2'd0;
    if (ev.direction > DIR_RIGHT || {1'b0, ev.layer} >= LAYERS) return res;
    opp      = ev.direction[1:0] ^ 2'd1;
    axis     = ev.direction[1];
    first    = ~ev.direction[0];
    held     = held_keys[ev.layer];
    opp_down = held[opp];
    if (ev.pressed) held_keys[ev.layer] = held | (4'b0001 << ev.direction[1:0]);
    else held_keys[ev.layer] = held & ~(4'b0001 << ev.direction[1:0]);
    if (!opp_down) return res;
    axis_bit = 2'b01 << axis;
    if (mode_q == MODE_NEUTRAL) begin
      if (axis == 1'b0 && !first) begin
        // down loses against a held up
        res.pass_event = 1'b0;
      end else begin
        res.side_action = ev.pressed ? SIDE_RELEASE : SIDE_PRESS;
        res.pass_event  = (axis == 1'b0);
      end
    end else if (ev.pressed) begin
      res.side_action = SIDE_RELEASE;
      if (first) last_winner[ev.layer] = last_winner[ev.layer] | axis_bit;
      else last_winner[ev.layer] = last_winner[ev.layer] & ~axis_bit;
    end else begin
      // releasing the winner hands the axis back to the held opposite side
      won = |(last_winner[ev.layer] & axis_bit);
      if (won == first) res.side_action = SIDE_PRESS;
      else res.pass_event = 1'b0;
    end
    if (res.side_action != SIDE_NONE) res.side_direction = opp;
    return res;
  endfunction

  always @(posedge clk) begin
    event_t  ev;
    result_t want;
    if (!rst_n) begin
      mode_q   = MODE_NEUTRAL;
      end_seen = 1'b0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
        held_keys[i]   = 4'd0;
        last_winner[i] = 2'd0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) mode_q = cfg_resolve_mode;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result transfer with nothing expected", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_pass_event !== want.pass_event)
            report("pass_event", out_pass_event, want.pass_event);
          if (out_side_action !== want.side_action)
            report("side_action", out_side_action, want.side_action);
          if (out_side_direction !== want.side_direction)
            report("side_direction", out_side_direction, want.side_direction);
        end
      end
      if (in_valid && !in_stall) begin
        ev.direction = in_direction;
        ev.pressed   = in_pressed;
        ev.layer     = in_layer;
        expected_results.push_back(resolve_event(ev));
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        if (expected_results.size() != 0)
          report("results never delivered", 0, expected_results.size());
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// top of the socd direction cleaner testbench: clock, reset, stimulus and verdict
module testbench;
  import socd_pkg::*;

  localparam int          LIMIT_CYCLES   = 200000;
  localparam int          HOLD_CYCLES    = 40;
  localparam int          PHASES         = 6;
  localparam int          PHASE_ITEMS    = 230;
  localparam logic        KEY_PRESS      = 1'b1;
  localparam logic        KEY_RELEASE    = 1'b0;
  localparam logic [DIR_W-1:0] DIR_OTHER_LO = 3'd4;
  localparam logic [DIR_W-1:0] DIR_OTHER_HI = 3'd7;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [DIR_W-1:0]   in_direction       = '0;
  logic               in_pressed         = 1'b0;
  logic [LAYER_W-1:0] in_layer           = '0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic               out_pass_event;
  logic [1:0]         out_side_action;
  logic [1:0]         out_side_direction;
  logic               cfg_valid          = 1'b0;
  logic               cfg_ready;
  logic               cfg_resolve_mode   = 1'b0;
  logic               end_check          = 1'b0;
  logic               tx_gaps            = 1'b1;
  logic               rx_gaps            = 1'b1;
  logic               long_hold_req      = 1'b0;
  logic               long_hold_taken    = 1'b0;
  int                 pending;
  int                 fail_count;
  int                 cycle_count        = 0;

  socd_direction_cleaner_unit dut (.*);

  socd_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  always begin
    @(posedge clk);
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(input logic [DIR_W-1:0] dir, input logic prs,
                            input logic [LAYER_W-1:0] lyr);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_direction <= dir;
    in_pressed   <= prs;
    in_layer     <= lyr;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly stick directions on a couple of layers so opposite keys meet often
  task automatic send_random_event();
    logic [DIR_W-1:0]   dir;
    logic [LAYER_W-1:0] lyr;
    dir = ($urandom_range(0, 99) < 85) ? DIR_W'($urandom_range(0, 3))
                                       : DIR_W'($urandom_range(4, 7));
    lyr = ($urandom_range(0, 99) < 70) ? LAYER_W'($urandom_range(0, 1))
                                       : LAYER_W'($urandom_range(0, 7));
    send_event(dir, 1'($urandom_range(0, 1)), lyr);
  endtask

  // drain every outstanding result, then write the mode register
  task automatic write_mode(input logic mode);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_resolve_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_NEUTRAL);
    // up beats down
    send_event(DIR_UP,    KEY_PRESS,   3'd0);
    send_event(DIR_DOWN,  KEY_PRESS,   3'd0);
    send_event(DIR_UP,    KEY_RELEASE, 3'd0);
    send_event(DIR_DOWN,  KEY_RELEASE, 3'd0);
    // left plus right goes neutral
    send_event(DIR_LEFT,  KEY_PRESS,   3'd7);
    send_event(DIR_RIGHT, KEY_PRESS,   3'd7);
    send_event(DIR_RIGHT, KEY_RELEASE, 3'd7);
    send_event(DIR_LEFT,  KEY_RELEASE, 3'd7);
    // other keys
    send_event(DIR_OTHER_LO, KEY_PRESS,   3'd3);
    send_event(DIR_OTHER_HI, KEY_RELEASE, 3'd5);
    // repeated press and release
    send_event(DIR_UP, KEY_PRESS,   3'd1);
    send_event(DIR_UP, KEY_PRESS,   3'd1);
    send_event(DIR_UP, KEY_RELEASE, 3'd1);
    send_event(DIR_UP, KEY_RELEASE, 3'd1);

    write_mode(MODE_LAST_WIN);
    send_event(DIR_LEFT,  KEY_PRESS,   3'd2);
    send_event(DIR_RIGHT, KEY_PRESS,   3'd2);
    send_event(DIR_LEFT,  KEY_RELEASE, 3'd2);
    send_event(DIR_RIGHT, KEY_RELEASE, 3'd2);
    send_event(DIR_UP,    KEY_PRESS,   3'd6);
    send_event(DIR_DOWN,  KEY_PRESS,   3'd6);
    send_event(DIR_DOWN,  KEY_RELEASE, 3'd6);
    send_event(DIR_UP,    KEY_RELEASE, 3'd6);
    // leave a key held across the mode change
    send_event(DIR_UP,    KEY_PRESS,   3'd4);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(ph[0] ? MODE_LAST_WIN : MODE_NEUTRAL);
      if (ph == PHASES - 1) begin
        tx_gaps <= 1'b0;
        rx_gaps <= 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 50) long_hold_req <= 1'b1;
        send_random_event();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ socd_direction_cleaner_unit.f @@
hw/rtl/socd_pkg.sv
hw/rtl/socd_resolve.sv
hw/rtl/socd_direction_cleaner_unit.sv
tb/sv/socd_checker.sv
tb/sv/testbench.sv
